### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the asynchronous reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dtss_pkg.sv
package dtss_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int DC_BITS        = 12;
	localparam int AMP_BITS       = 11;
	localparam int STEP_BITS      = 32;
	localparam int MAG_BITS       = 15;
	localparam int TERM_BITS      = AMP_BITS + 1;
	localparam int SUM_BITS       = 15;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	localparam logic [DC_BITS-1:0]   DC_OFFSET_RST    = 12'd2048;
	localparam logic [AMP_BITS-1:0]  AMPLITUDE_A_RST  = 11'd500;
	localparam logic [STEP_BITS-1:0] PHASE_STEP_A_RST = 32'd42955364;
	localparam logic [AMP_BITS-1:0]  AMPLITUDE_B_RST  = 11'd0;
	localparam logic [STEP_BITS-1:0] PHASE_STEP_B_RST = 32'd103087000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_DC_OFFSET    = 3'd0,
		CFG_AMPLITUDE_A  = 3'd1,
		CFG_PHASE_STEP_A = 3'd2,
		CFG_AMPLITUDE_B  = 3'd3,
		CFG_PHASE_STEP_B = 3'd4
	} cfg_reg_t;

	// Load enables of the tone pipeline stages.
	typedef struct packed {
		logic accept;
		logic en_s2;
		logic en_s3;
	} adv_t;

	// Sine magnitude for quarter-wave position a out of 2^qbits, in 0.15 format.
	// The angle is worked in Q30 with a Taylor series up to the ninth power.
	function automatic logic [MAG_BITS-1:0] sine_mag(input logic [63:0] a,
		input int unsigned qbits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        t;
		logic [63:0]        mag;
		logic signed [63:0] s;
		x  = (a * HALF_PI_Q30) >> qbits;
		x2 = (x * x) >> 30;
		t  = x;
		s  = signed'(x);
		t  = ((t * x2) >> 30) / 64'd6;
		s  = s - signed'(t);
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + signed'(t);
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - signed'(t);
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + signed'(t);
		if (s < 0) begin
			s = '0;
		end
		mag = (unsigned'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return mag[MAG_BITS-1:0];
	endfunction

endpackage

### rtl/core/dtss_tone.sv
module dtss_tone #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  dtss_pkg::adv_t                              adv,
	input  logic                                        clear_phase,
	input  logic [dtss_pkg::STEP_BITS-1:0]              phase_step,
	input  logic [dtss_pkg::AMP_BITS-1:0]               amplitude,
	output logic signed [dtss_pkg::TERM_BITS-1:0]       term_s3
);

	localparam int QBITS   = TABLE_ADDR_BITS - 2;
	localparam int QUARTER = 1 << QBITS;
	localparam logic [QBITS:0] QUARTER_A = (QBITS + 1)'(QUARTER);
	localparam int PROD_BITS = dtss_pkg::AMP_BITS + dtss_pkg::MAG_BITS;

	typedef logic [dtss_pkg::MAG_BITS-1:0] mag_tab_t [QUARTER+1];

	function automatic mag_tab_t build_table();
		mag_tab_t tab;
		for (int i = 0; i <= QUARTER; i++) begin
			tab[i] = dtss_pkg::sine_mag(64'(i), QBITS);
		end
		return tab;
	endfunction

	localparam mag_tab_t SINE_MAG = build_table();

	logic [PHASE_BITS-1:0]            phase_q;
	logic [PHASE_BITS-1:0]            base;
	logic [PHASE_BITS-1:0]            step_ext;
	logic [1:0]                       quad;
	logic [QBITS-1:0]                 rem;
	logic [QBITS:0]                   addr;
	logic [QBITS:0]                   addr_s1;
	logic                             neg_s1;
	logic [dtss_pkg::MAG_BITS-1:0]    mag_s2;
	logic                             neg_s2;
	logic [PROD_BITS-1:0]             prod;
	logic [dtss_pkg::AMP_BITS-1:0]    prod_hi;
	logic signed [dtss_pkg::TERM_BITS-1:0] term;

	generate
		if (PHASE_BITS > dtss_pkg::STEP_BITS) begin : g_step_wide
			assign step_ext = {{(PHASE_BITS - dtss_pkg::STEP_BITS){1'b0}}, phase_step};
		end else begin : g_step_narrow
			assign step_ext = phase_step[PHASE_BITS-1:0];
		end
	endgenerate

	always_comb begin
		base = clear_phase ? '0 : phase_q;
		quad = base[PHASE_BITS-1 -: 2];
		rem  = base[PHASE_BITS-3 -: QBITS];
		addr = quad[0] ? (QUARTER_A - {1'b0, rem}) : {1'b0, rem};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (adv.accept) begin
			phase_q <= base + step_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.accept) begin
			addr_s1 <= addr;
			neg_s1  <= quad[1];
		end
		if (adv.en_s2) begin
			mag_s2 <= SINE_MAG[addr_s1];
			neg_s2 <= neg_s1;
		end
		if (adv.en_s3) begin
			term_s3 <= term;
		end
	end

	always_comb begin
		prod    = PROD_BITS'(amplitude) * PROD_BITS'(mag_s2);
		prod_hi = prod[PROD_BITS-1 -: dtss_pkg::AMP_BITS];
		term    = neg_s2 ? -signed'({1'b0, prod_hi}) : signed'({1'b0, prod_hi});
	end

endmodule

### rtl/core/dual_tone_sine_synth_unit.sv
// Channel  Handshake                Payload
// in       in_valid / in_ready      clear_phase
// out      out_valid / out_ready    sample, clipped
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One sample tick is accepted every cycle unless the output stalls; after its transaction is
// accepted, a result passes four registers: the table address, the table read, the amplitude
// multiply and the summing output register with saturation.
// Reset clears the phase accumulators and the stage valid flags and restores the
// register defaults. A stalled output holds its result while the earlier stages keep
// filling until every stage is occupied. Configuration writes are always taken.
module dual_tone_sine_synth_unit #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    clear_phase,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [dtss_pkg::SAMPLE_BITS-1:0]        sample,
	output logic                                    clipped,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [dtss_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [dtss_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	logic [dtss_pkg::DC_BITS-1:0]   dc_offset_q;
	logic [dtss_pkg::AMP_BITS-1:0]  amplitude_a_q;
	logic [dtss_pkg::STEP_BITS-1:0] phase_step_a_q;
	logic [dtss_pkg::AMP_BITS-1:0]  amplitude_b_q;
	logic [dtss_pkg::STEP_BITS-1:0] phase_step_b_q;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic out_valid_q;
	logic free_out;
	logic free3;
	logic free2;
	logic free1;
	dtss_pkg::adv_t adv;

	logic signed [dtss_pkg::TERM_BITS-1:0] term_a_s3;
	logic signed [dtss_pkg::TERM_BITS-1:0] term_b_s3;
	logic signed [dtss_pkg::SUM_BITS-1:0]  sum;
	logic [dtss_pkg::SAMPLE_BITS-1:0]      sat;
	logic                                  clip;
	logic [dtss_pkg::SAMPLE_BITS-1:0]      sample_q;
	logic                                  clipped_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_offset_q    <= dtss_pkg::DC_OFFSET_RST;
			amplitude_a_q  <= dtss_pkg::AMPLITUDE_A_RST;
			phase_step_a_q <= dtss_pkg::PHASE_STEP_A_RST;
			amplitude_b_q  <= dtss_pkg::AMPLITUDE_B_RST;
			phase_step_b_q <= dtss_pkg::PHASE_STEP_B_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dtss_pkg::CFG_DC_OFFSET:    dc_offset_q    <= cfg_data[dtss_pkg::DC_BITS-1:0];
				dtss_pkg::CFG_AMPLITUDE_A:  amplitude_a_q  <= cfg_data[dtss_pkg::AMP_BITS-1:0];
				dtss_pkg::CFG_PHASE_STEP_A: phase_step_a_q <= cfg_data[dtss_pkg::STEP_BITS-1:0];
				dtss_pkg::CFG_AMPLITUDE_B:  amplitude_b_q  <= cfg_data[dtss_pkg::AMP_BITS-1:0];
				dtss_pkg::CFG_PHASE_STEP_B: phase_step_b_q <= cfg_data[dtss_pkg::STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its content moves on this cycle.
	always_comb begin
		free_out   = !out_valid_q || out_ready;
		free3      = !v_s3 || free_out;
		free2      = !v_s2 || free3;
		free1      = !v_s1 || free2;
		adv.accept = in_valid && free1;
		adv.en_s2  = v_s1 && free2;
		adv.en_s3  = v_s2 && free3;
	end

	assign in_ready = free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= in_valid;
			end
			if (free2) begin
				v_s2 <= v_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			if (free_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	dtss_tone #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_tone_a (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.clear_phase (clear_phase),
		.phase_step  (phase_step_a_q),
		.amplitude   (amplitude_a_q),
		.term_s3     (term_a_s3)
	);

	dtss_tone #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_tone_b (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.clear_phase (clear_phase),
		.phase_step  (phase_step_b_q),
		.amplitude   (amplitude_b_q),
		.term_s3     (term_b_s3)
	);

	always_comb begin
		sum = signed'({{(dtss_pkg::SUM_BITS - dtss_pkg::DC_BITS){1'b0}}, dc_offset_q})
			+ dtss_pkg::SUM_BITS'(term_a_s3)
			+ dtss_pkg::SUM_BITS'(term_b_s3);
		if (sum < 0) begin
			sat  = '0;
			clip = 1'b1;
		end else if (sum > signed'({{(dtss_pkg::SUM_BITS - dtss_pkg::SAMPLE_BITS){1'b0}},
			dtss_pkg::SAMPLE_MAX})) begin
			sat  = dtss_pkg::SAMPLE_MAX;
			clip = 1'b1;
		end else begin
			sat  = sum[dtss_pkg::SAMPLE_BITS-1:0];
			clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (free_out && v_s3) begin
			sample_q  <= sat;
			clipped_q <= clip;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign clipped   = clipped_q;

endmodule

### rtl/core/dtss_checker.sv
`include "assert_macros.svh"

module dtss_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               clear_phase,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [dtss_pkg::SAMPLE_BITS-1:0]   sample,
	input logic                               clipped
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(clipped), "output transaction changed while stalled")
	`ASSERT_CLK(a_in_hold, clk, arst_n, in_valid && !in_ready |=> in_valid && $stable(clear_phase), "input transaction changed while stalled")
	`ASSERT_CLK(a_clip_range, clk, arst_n, out_valid && clipped |-> sample == '0 || sample == dtss_pkg::SAMPLE_MAX, "clipped sample is not at a converter limit")
	`ASSERT_CLK(a_ready_free, clk, arst_n, !out_valid || out_ready |-> in_ready, "input stalled although the output is free")

endmodule

bind dual_tone_sine_synth_unit dtss_checker u_dtss_checker (.*);
